[hw/rtl/websocket_frame_unmasker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame unmasker
// Same-cycle and next-cycle implication checks, reset-qualified.
// Both macros expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`ifndef SYNTHESIS
// ante true implies cons true in the same cycle
`define WFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// ante true implies cons true in the next cycle
`define WFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/wfu_pkg.sv]
// ----------------------------------------------------------------------------
// wfu_pkg
// Shared types and constants of the frame unmasker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wfu_pkg;

  // Header field constants
  localparam logic [7:0] MASK_BIT_M  = 8'h80;
  localparam logic [7:0] LEN7_M      = 8'h7F;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT = 2'd1;
  localparam logic [1:0] ST_UNSUP     = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // One input transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/websocket_frame_unmasker.sv]
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Byte-serial frame decoder: parses the header, collects the mask key and
// outputs unmasked payload bytes with end and status flags.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------
//   in      | in_valid_i, in_stall_o | in_byte_i, buffer_end_i
//   out     | out_valid_o, out_stall_i | payload_byte_o, byte_valid_o,
//           |                        | frame_end_o, status_o
//
// One byte per cycle while the result side does not stall: an input register,
// the header/unmask logic and a result register; an accepted byte is held in
// the input register, decoded, and its result is loaded into the result register.
// Bytes that give no result pass the decoder even while the result is stalled.
// Reset returns the parser to the first header byte and empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_unmasker
  import wfu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       buffer_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      payload_byte_o,
  output logic            byte_valid_o,
  output logic            frame_end_o,
  output logic [1:0]      status_o
);

  logic  item_valid;
  item_t item;
  logic  res_valid;
  res_t  res;
  logic  out_free;
  logic  adv;
  res_t  out_res;

  // Decode a held byte when it gives no result or its result has somewhere to go
  assign adv = item_valid && (out_free || !res_valid);

  wfu_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .buffer_end_i (buffer_end_i),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wfu_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .adv_i        (adv),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wfu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_load_i  (adv && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign payload_byte_o = out_res.payload_byte;
  assign byte_valid_o   = out_res.byte_valid;
  assign frame_end_o    = out_res.frame_end;
  assign status_o       = out_res.status;

endmodule

`default_nettype wire

[hw/rtl/wfu_in_reg.sv]
// ----------------------------------------------------------------------------
// wfu_in_reg
// Input register: captures one byte transaction and holds it until decoded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfu_in_reg
  import wfu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire logic  [7:0] in_byte_i,
  input  wire logic  buffer_end_i,
  input  wire logic  adv_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q;
  logic  valid_d;
  logic  load;
  item_t item_q;

  // Stall only while a held transaction cannot move on
  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  // Refill on load, drop on advance
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data <= in_byte_i;
      item_q.last <= buffer_end_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[hw/rtl/wfu_decoder.sv]
// ----------------------------------------------------------------------------
// wfu_decoder
// Frame header parser, mask key store and payload unmasking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_unmasker_assert.svh"

module wfu_decoder
  import wfu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  input  wire logic  adv_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT_HI = 3'd2;
  localparam logic [2:0] PH_EXT_LO = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_DRAIN  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic        masked_q, masked_d;
  logic [15:0] rem_q, rem_d;
  logic [1:0]  kidx_q, kidx_d;
  logic [7:0]  key_q [4];
  logic        key_we;
  logic        len_known;
  logic        pay_start;
  logic        res_v;
  res_t        res;
  logic [6:0]  len7;
  logic [7:0]  data_v;

  assign len7   = item_i.data[6:0] & LEN7_M[6:0];
  assign data_v = masked_q ? (item_i.data ^ key_q[kidx_q]) : item_i.data;

  // Next state and result for the held transaction
  always_comb begin
    phase_d   = phase_q;
    masked_d  = masked_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    key_we    = 1'b0;
    len_known = 1'b0;
    pay_start = 1'b0;
    res_v     = 1'b0;
    res       = '0;

    case (phase_q)
      PH_HDR0: begin
        if (item_i.last) begin
          res_v     = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_TOO_SHORT;
        end else begin
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        masked_d = |(item_i.data & MASK_BIT_M);
        if (len7 == LEN_EXT64) begin
          res_v         = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_UNSUP;
        end else if (len7 == LEN_EXT16) begin
          phase_d = PH_EXT_HI;
        end else begin
          rem_d     = {9'd0, len7};
          len_known = 1'b1;
        end
      end
      PH_EXT_HI: begin
        rem_d   = {item_i.data, 8'h00};
        phase_d = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        rem_d     = {rem_q[15:8], item_i.data};
        len_known = 1'b1;
      end
      PH_MASK: begin
        key_we = 1'b1;
        if (kidx_q == 2'd3) begin
          pay_start = 1'b1;
        end else begin
          kidx_d = kidx_q + 2'd1;
        end
      end
      PH_DATA: begin
        kidx_d           = kidx_q + 2'd1;
        rem_d            = rem_q - 16'd1;
        res_v            = 1'b1;
        res.payload_byte = data_v;
        res.byte_valid   = 1'b1;
        if (rem_d == 16'd0) begin
          res.frame_end = 1'b1;
        end else if (item_i.last) begin
          res.frame_end = 1'b1;
          res.status    = ST_TRUNC;
        end
      end
      default: begin
      end
    endcase

    // Length settled: collect the key or start the payload
    if (len_known) begin
      if (masked_d) begin
        kidx_d  = 2'd0;
        phase_d = PH_MASK;
      end else begin
        pay_start = 1'b1;
      end
    end

    // Payload start: empty frame closes at once
    if (pay_start) begin
      kidx_d = 2'd0;
      if (rem_d == 16'd0) begin
        res_v         = 1'b1;
        res.frame_end = 1'b1;
        res.status    = ST_OK;
      end else begin
        phase_d = PH_DATA;
      end
    end

    // Frame closed: ignore bytes until the buffer ends
    if (res_v && res.frame_end) begin
      phase_d = PH_DRAIN;
    end

    // Buffer end: flag an open frame and rearm
    if (item_i.last) begin
      if ((phase_q != PH_DRAIN) && !res_v) begin
        res_v         = 1'b1;
        res.frame_end = 1'b1;
        res.status    = ST_TRUNC;
      end
      phase_d  = PH_HDR0;
      masked_d = 1'b0;
      rem_d    = 16'd0;
      kidx_d   = 2'd0;
    end
  end

  // Advance state on each decoded transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      masked_q <= 1'b0;
      rem_q    <= 16'd0;
      kidx_q   <= 2'd0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      kidx_q   <= kidx_d;
    end
  end

  // Store mask key bytes
  always_ff @(posedge clk_i) begin
    if (adv_i && key_we) begin
      key_q[kidx_q] <= item_i.data;
    end
  end

  assign res_valid_o = item_valid_i && res_v;
  assign res_o       = res;

  `WFU_ASSERT_IMPL(a_nodata_ends, clk_i, rst_ni, res_valid_o && !res_o.byte_valid, res_o.frame_end, "result without data must close the frame")
  `WFU_ASSERT_IMPL(a_status_ends, clk_i, rst_ni, res_valid_o && (res_o.status != ST_OK), res_o.frame_end, "error status must close the frame")
  `WFU_ASSERT_IMPL(a_data_phase, clk_i, rst_ni, res_valid_o && res_o.byte_valid, phase_q == PH_DATA, "payload byte outside data phase")
  `WFU_ASSERT_NEXT(a_end_rearm, clk_i, rst_ni, adv_i && item_i.last, phase_q == PH_HDR0, "buffer end did not rearm the header parser")

endmodule

`default_nettype wire

[hw/rtl/wfu_out_reg.sv]
// ----------------------------------------------------------------------------
// wfu_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfu_out_reg
  import wfu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_load_i,
  input  wire res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  logic valid_q;
  logic valid_d;
  res_t res_q;

  // Room when empty or being taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture result
  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
